@@ rtl/core/dpf_pkg.sv @@
// Shared constants and types for the decimal power formatter.
// Depends on nothing; imported by the top level and the digit MAC.
package dpf_pkg;

  // BCD digit
  localparam int DigitW = 4;
  typedef logic [DigitW-1:0] digit_t;

  // Default sizing, handed to the top level parameters
  localparam int DefDigitStore  = 160;
  localparam int DefBaseDigits  = 6;
  localparam int DefMaxExponent = 25;

  // Port field widths
  localparam int BaseW  = 20;
  localparam int FracW  = 3;
  localparam int ExpW   = 5;
  localparam int ChunkW = 64;
  localparam int CountW = 4;

  // Text chunking
  localparam int ChunkChars = 8;
  localparam int CharIdxW   = $clog2(ChunkChars);
  localparam int MaxChunks  = 19;
  localparam int MaxChars   = MaxChunks * ChunkChars;

  // Divide by ten through a reciprocal: 20-bit operands
  localparam logic [BaseW-1:0] Div10Mul = 20'd838861;
  localparam int               Div10Shift = 23;

  // Divide by ten for sums below one hundred
  localparam logic [7:0] SmallDiv10Mul = 8'd205;
  localparam int         SmallDiv10Shift = 11;

  // ASCII codes
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiDot  = 8'h2E;

endpackage

@@ rtl/core/dpf_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
module dpf_ram #(
  parameter int Width = 4,
  parameter int Depth = 160,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dpf_digit_mac.sv @@
// BCD digit multiply-accumulate: acc + mult * digit + carry, split into
// sum digit and carry digit. Depends on dpf_pkg.
module dpf_digit_mac (
  input  dpf_pkg::digit_t acc_i,
  input  dpf_pkg::digit_t mult_i,
  input  dpf_pkg::digit_t digit_i,
  input  dpf_pkg::digit_t carry_i,
  output dpf_pkg::digit_t sum_o,
  output dpf_pkg::digit_t carry_o
);
  import dpf_pkg::*;

  // sum is at most 9 + 81 + 9 = 99
  localparam int SumW = 7;
  localparam int ProdW = SumW + 8;

  logic [SumW-1:0]  sum_full;
  logic [ProdW-1:0] recip;
  digit_t           quot;

  assign sum_full = SumW'(acc_i) + SumW'(mult_i) * SumW'(digit_i) + SumW'(carry_i);

  // divide by ten through the reciprocal, then take the remainder
  assign recip   = ProdW'(sum_full) * ProdW'(SmallDiv10Mul);
  assign quot    = DigitW'(recip >> SmallDiv10Shift);
  assign carry_o = quot;
  assign sum_o   = DigitW'(sum_full - SumW'({quot, 3'b000}) - SumW'({quot, 1'b0}));

endmodule

@@ rtl/core/decimal_power_formatter_top.sv @@
// Top level of the decimal power formatter: sequencer, two ping-pong digit
// RAMs and the shared digit MAC. Depends on dpf_pkg, dpf_ram, dpf_digit_mac.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the last text chunk has been strobed out. The base is split into
// BASE_DIGITS BCD digits (one per cycle), the power store is loaded, and
// each of the exponent-1 multiplies runs one BCD digit product per cycle
// through the single digit MAC: row 0 and the row of every nonzero base
// digit are run, a zero digit's row is skipped. A scan finds the text
// bounds, S_LEN sets the length, then each character is read in S_CRD and
// appended in S_CWR, since it comes from the RAM's registered port.
// Results appear on text_chunk_o, char_count_o and last_chunk_o for exactly
// one cycle while result_valid_o is high; the receiver cannot stall them.
// A zero result gives one chunk with char_count_o of zero and last_chunk_o
// set.
module decimal_power_formatter_top #(
  parameter int DIGIT_STORE  = dpf_pkg::DefDigitStore,
  parameter int BASE_DIGITS  = dpf_pkg::DefBaseDigits,
  parameter int MAX_EXPONENT = dpf_pkg::DefMaxExponent
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [dpf_pkg::BaseW-1:0]    base_value_i,
  input  logic [dpf_pkg::FracW-1:0]    fraction_digits_i,
  input  logic [dpf_pkg::ExpW-1:0]     exponent_i,
  output logic                         result_valid_o,
  output logic [dpf_pkg::ChunkW-1:0]   text_chunk_o,
  output logic [dpf_pkg::CountW-1:0]   char_count_o,
  output logic                         last_chunk_o
);
  import dpf_pkg::*;

  localparam int IW  = $clog2(DIGIT_STORE);
  localparam int CW  = $clog2(DIGIT_STORE + 1);
  localparam int LW  = $clog2(DIGIT_STORE + 2);
  localparam int BIW = (BASE_DIGITS > 1) ? $clog2(BASE_DIGITS) : 1;
  localparam int PW  = FracW + ExpW;

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_INIT, S_MROW, S_MRUN, S_MEND,
    S_SCAN, S_SCEND, S_LEN, S_CRD, S_CWR
  } state_e;

  state_e            state_q, state_d;
  logic [BaseW-1:0]  x_q, x_d;
  logic [ExpW-1:0]   expo_q, expo_d;
  logic [ExpW-1:0]   rem_q, rem_d;
  logic [CW-1:0]     point_q, point_d;
  logic [BIW-1:0]    i_q, i_d;
  logic [IW-1:0]     k_q, k_d;
  logic              vb_q, vb_d;
  logic [IW-1:0]     wa_q, wa_d;
  digit_t            carry_q, carry_d;
  logic              sel_q, sel_d;
  logic              has_top_q, has_top_d;
  logic [IW-1:0]     top_q, top_d;
  logic              has_low_q, has_low_d;
  logic [IW-1:0]     low_q, low_d;
  logic [CW-1:0]     nint_q, nint_d;
  logic [LW-1:0]     len_q, len_d;
  logic [LW-1:0]     t_q, t_d;
  logic [CharIdxW-1:0] cc_q, cc_d;
  logic [ChunkW-1:0] chunk_q, chunk_d;
  logic              valid_q, valid_d;
  logic [ChunkW-1:0] text_q, text_d;
  logic [CountW-1:0] count_q, count_d;
  logic              last_q, last_d;

  // base digit store
  digit_t            dig_q [BASE_DIGITS];
  logic [BIW-1:0]    dig_addr;
  digit_t            dig_rd;

  // source (power) and destination (product) RAM views
  logic              src_we, dst_we;
  logic [IW-1:0]     src_waddr, src_raddr, dst_waddr, dst_raddr;
  digit_t            src_wdata, dst_wdata, src_rdata, dst_rdata;
  logic              a_we, b_we;
  logic [IW-1:0]     a_waddr, a_raddr, b_waddr, b_raddr;
  digit_t            a_wdata, b_wdata, a_rdata, b_rdata;

  // shared arithmetic
  digit_t            mac_acc, mac_sum, mac_carry;
  logic [2*BaseW-1:0] split_prod;
  logic [BaseW-1:0]  split_q;
  logic [BaseW-1:0]  split_q10;
  digit_t            split_digit;

  // item capture helpers
  logic [FracW-1:0]  frac_sat;
  logic [ExpW-1:0]   expo_sat;
  logic [PW-1:0]     point_full;

  // length and emit helpers
  logic [CW-1:0]     nint_calc;
  logic [LW-1:0]     frac_part;
  logic [LW-1:0]     len_full;
  logic [LW-1:0]     len_cap;
  logic              t_lt_nint;
  logic              is_dot;
  logic [LW:0]       emit_addr;
  logic              t_last;
  logic [7:0]        emit_char;
  logic [ChunkW-1:0] chunk_next;
  logic              mul_done;

  // digit split: one decimal digit per cycle through a reciprocal multiply
  assign split_prod  = (2*BaseW)'(x_q) * (2*BaseW)'(Div10Mul);
  assign split_q     = BaseW'(split_prod >> Div10Shift);
  assign split_q10   = BaseW'({split_q, 3'b000}) + BaseW'({split_q, 1'b0});
  assign split_digit = DigitW'(x_q - split_q10);

  always_ff @(posedge clk_i) begin
    if (state_q == S_SPLIT) begin
      dig_q[i_q] <= split_digit;
    end
  end

  assign dig_rd = dig_q[dig_addr];

  // saturate fields and place the point
  assign frac_sat   = (int'(fraction_digits_i) > BASE_DIGITS) ? FracW'(BASE_DIGITS)
                                                              : fraction_digits_i;
  assign expo_sat   = (int'(exponent_i) > MAX_EXPONENT) ? ExpW'(MAX_EXPONENT) : exponent_i;
  assign point_full = PW'(frac_sat) * PW'(expo_sat);

  // digit MAC: row 0 starts from an empty product
  assign mac_acc = (i_q == '0) ? '0 : dst_rdata;

  dpf_digit_mac u_mac (
    .acc_i   (mac_acc),
    .mult_i  (dig_rd),
    .digit_i (src_rdata),
    .carry_i (carry_q),
    .sum_o   (mac_sum),
    .carry_o (mac_carry)
  );

  // text length from scan results
  assign nint_calc = has_top_q ? (CW'(top_q) - point_q + CW'(1)) : '0;
  assign frac_part = has_low_q ? (LW'(point_q) - LW'(low_q) + LW'(1)) : '0;
  assign len_full  = LW'(nint_calc) + frac_part;
  assign len_cap   = (int'(len_full) > MaxChars) ? LW'(MaxChars) : len_full;

  // emit address: integer part downward from the top, then the fraction
  assign t_lt_nint = (LW + 1)'(t_q) < (LW + 1)'(nint_q);
  assign is_dot    = has_low_q && ((LW + 1)'(t_q) == (LW + 1)'(nint_q));
  assign emit_addr = (LW + 1)'(point_q) + (LW + 1)'(nint_q) - (LW + 1)'(t_q)
                   - (LW + 1)'(t_lt_nint);
  assign t_last    = ((LW + 1)'(t_q) + (LW + 1)'(1)) == (LW + 1)'(len_q);
  assign emit_char = is_dot ? AsciiDot : (AsciiZero + 8'(src_rdata));

  always_comb begin
    chunk_next = chunk_q;
    chunk_next[cc_q*8 +: 8] = emit_char;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    expo_d    = expo_q;
    rem_d     = rem_q;
    point_d   = point_q;
    i_d       = i_q;
    k_d       = k_q;
    vb_d      = vb_q;
    wa_d      = wa_q;
    carry_d   = carry_q;
    sel_d     = sel_q;
    has_top_d = has_top_q;
    top_d     = top_q;
    has_low_d = has_low_q;
    low_d     = low_q;
    nint_d    = nint_q;
    len_d     = len_q;
    t_d       = t_q;
    cc_d      = cc_q;
    chunk_d   = chunk_q;
    valid_d   = 1'b0;
    text_d    = text_q;
    count_d   = count_q;
    last_d    = last_q;
    mul_done  = 1'b0;

    dig_addr  = i_q;
    src_we    = 1'b0;
    src_waddr = k_q;
    src_wdata = '0;
    src_raddr = k_q;
    dst_we    = 1'b0;
    dst_waddr = wa_q;
    dst_wdata = mac_sum;
    dst_raddr = k_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          x_d     = base_value_i;
          expo_d  = expo_sat;
          point_d = (int'(point_full) > DIGIT_STORE) ? CW'(DIGIT_STORE) : CW'(point_full);
          i_d     = '0;
          state_d = S_SPLIT;
        end
      end

      S_SPLIT: begin
        x_d = split_q;
        if (i_q == BIW'(BASE_DIGITS - 1)) begin
          i_d     = '0;
          k_d     = '0;
          state_d = S_INIT;
        end else begin
          i_d = i_q + BIW'(1);
        end
      end

      // load the power store with the base, or with one for a zero exponent
      S_INIT: begin
        dig_addr = BIW'(k_q);
        src_we   = 1'b1;
        if (expo_q == '0) begin
          src_wdata = (k_q == '0) ? digit_t'(1) : '0;
        end else if (int'(k_q) < BASE_DIGITS) begin
          src_wdata = dig_rd;
        end
        if (k_q == IW'(DIGIT_STORE - 1)) begin
          i_d = '0;
          if (expo_q > ExpW'(1)) begin
            rem_d   = expo_q - ExpW'(1);
            state_d = S_MROW;
          end else begin
            rem_d     = '0;
            k_d       = '0;
            vb_d      = 1'b0;
            has_top_d = 1'b0;
            has_low_d = 1'b0;
            state_d   = S_SCAN;
          end
        end else begin
          k_d = k_q + IW'(1);
        end
      end

      // pick the next row: row 0 always, later rows only for nonzero digits
      S_MROW: begin
        if (i_q == '0 || dig_rd != '0) begin
          k_d     = '0;
          carry_d = '0;
          vb_d    = 1'b0;
          state_d = S_MRUN;
        end else if (i_q == BIW'(BASE_DIGITS - 1)) begin
          mul_done = 1'b1;
        end else begin
          i_d = i_q + BIW'(1);
        end
      end

      // issue reads ahead of the MAC write-back, which waits for the registered RAM data
      S_MRUN: begin
        src_raddr = k_q;
        dst_raddr = IW'(i_q) + k_q;
        vb_d      = 1'b1;
        wa_d      = dst_raddr;
        if (vb_q) begin
          dst_we  = 1'b1;
          carry_d = mac_carry;
        end
        if (dst_raddr == IW'(DIGIT_STORE - 1)) begin
          state_d = S_MEND;
        end else begin
          k_d = k_q + IW'(1);
        end
      end

      S_MEND: begin
        dst_we = 1'b1;
        vb_d   = 1'b0;
        if (i_q == BIW'(BASE_DIGITS - 1)) begin
          mul_done = 1'b1;
        end else begin
          i_d     = i_q + BIW'(1);
          state_d = S_MROW;
        end
      end

      // find the highest integer digit and the lowest fraction digit
      S_SCAN, S_SCEND: begin
        if (state_q == S_SCAN) begin
          src_raddr = k_q;
          vb_d      = 1'b1;
          wa_d      = k_q;
          if (k_q == IW'(DIGIT_STORE - 1)) begin
            state_d = S_SCEND;
          end else begin
            k_d = k_q + IW'(1);
          end
        end else begin
          vb_d    = 1'b0;
          state_d = S_LEN;
        end
        if (vb_q && src_rdata != '0) begin
          if (CW'(wa_q) < point_q) begin
            if (!has_low_q) begin
              has_low_d = 1'b1;
              low_d     = wa_q;
            end
          end else begin
            has_top_d = 1'b1;
            top_d     = wa_q;
          end
        end
      end

      S_LEN: begin
        if (len_cap == '0) begin
          valid_d = 1'b1;
          text_d  = '0;
          count_d = '0;
          last_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          nint_d  = nint_calc;
          len_d   = len_cap;
          t_d     = '0;
          cc_d    = '0;
          chunk_d = '0;
          state_d = S_CRD;
        end
      end

      S_CRD: begin
        src_raddr = IW'(emit_addr);
        state_d   = S_CWR;
      end

      // append one character, send the chunk when full or at the end
      S_CWR: begin
        if (cc_q == CharIdxW'(ChunkChars - 1) || t_last) begin
          valid_d = 1'b1;
          text_d  = chunk_next;
          count_d = CountW'(cc_q) + CountW'(1);
          last_d  = t_last;
          chunk_d = '0;
          cc_d    = '0;
        end else begin
          chunk_d = chunk_next;
          cc_d    = cc_q + CharIdxW'(1);
        end
        t_d     = t_q + LW'(1);
        state_d = t_last ? S_IDLE : S_CRD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // end of one multiply: product becomes the power
    if (mul_done) begin
      sel_d = ~sel_q;
      rem_d = rem_q - ExpW'(1);
      i_d   = '0;
      if (rem_q == ExpW'(1)) begin
        k_d       = '0;
        vb_d      = 1'b0;
        has_top_d = 1'b0;
        has_low_d = 1'b0;
        state_d   = S_SCAN;
      end else begin
        state_d = S_MROW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rem_q     <= '0;
      i_q       <= '0;
      k_q       <= '0;
      vb_q      <= 1'b0;
      sel_q     <= 1'b0;
      has_top_q <= 1'b0;
      has_low_q <= 1'b0;
      t_q       <= '0;
      cc_q      <= '0;
      valid_q   <= 1'b0;
      text_q    <= '0;
      count_q   <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rem_q     <= rem_d;
      i_q       <= i_d;
      k_q       <= k_d;
      vb_q      <= vb_d;
      sel_q     <= sel_d;
      has_top_q <= has_top_d;
      has_low_q <= has_low_d;
      t_q       <= t_d;
      cc_q      <= cc_d;
      valid_q   <= valid_d;
      text_q    <= text_d;
      count_q   <= count_d;
      last_q    <= last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    expo_q  <= expo_d;
    point_q <= point_d;
    wa_q    <= wa_d;
    carry_q <= carry_d;
    top_q   <= top_d;
    low_q   <= low_d;
    nint_q  <= nint_d;
    len_q   <= len_d;
    chunk_q <= chunk_d;
  end

  // ping-pong mapping of source and destination onto the two RAMs
  always_comb begin
    a_we      = sel_q ? dst_we    : src_we;
    a_waddr   = sel_q ? dst_waddr : src_waddr;
    a_wdata   = sel_q ? dst_wdata : src_wdata;
    a_raddr   = sel_q ? dst_raddr : src_raddr;
    b_we      = sel_q ? src_we    : dst_we;
    b_waddr   = sel_q ? src_waddr : dst_waddr;
    b_wdata   = sel_q ? src_wdata : dst_wdata;
    b_raddr   = sel_q ? src_raddr : dst_raddr;
    src_rdata = sel_q ? b_rdata   : a_rdata;
    dst_rdata = sel_q ? a_rdata   : b_rdata;
  end

  dpf_ram #(
    .Width (DigitW),
    .Depth (DIGIT_STORE)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  dpf_ram #(
    .Width (DigitW),
    .Depth (DIGIT_STORE)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign text_chunk_o   = text_q;
  assign char_count_o   = count_q;
  assign last_chunk_o   = last_q;

endmodule
